/* sv/nsc_pkg.sv */
// Shared types and constants for the NMEA sentence checker.
`default_nettype none

package nsc_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Field counter saturation point; content in this field or later is dropped
   localparam logic [3:0] MAX_FIELDS = 4'd12;

   // Header layout: two source characters, three ID characters, one separator
   localparam int HEADER_LEN = 6;

   // Result kinds
   localparam logic KIND_CONTENT = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict codes
   localparam logic [1:0] VERDICT_OK       = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_BAD      = 2'd2;

   // One result transaction
   typedef struct packed {
      logic        kind;
      logic [3:0]  field_index;
      logic [7:0]  content_char;
      logic [15:0] talker_source;
      logic [23:0] sentence_id;
      logic [1:0]  verdict;
   } nsc_rsp_type;

endpackage

`default_nettype wire

/* sv/nsc_if.sv */
// Valid/ready channel interfaces for received bytes and checker results.
`default_nettype none

interface nsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  field_index;
   logic [7:0]  content_char;
   logic [15:0] talker_source;
   logic [23:0] sentence_id;
   logic [1:0]  verdict;

   modport source (output valid, output kind, output field_index, output content_char,
                   output talker_source, output sentence_id, output verdict,
                   input ready);
   modport sink   (input valid, input kind, input field_index, input content_char,
                   input talker_source, input sentence_id, input verdict,
                   output ready);
endinterface

`default_nettype wire

/* sv/nsc_in_reg.sv */
// Input register stage holding one received byte for the parser.
`default_nettype none

module nsc_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte,
   input  wire logic       consume,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       accept;

   // Take a new byte when the stage is empty or drains this cycle
   assign req_ready = !valid_ff || consume;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

`default_nettype wire

/* sv/nsc_parser.sv */
// Sentence parser: running checksum, header capture, field split and verdict.
`default_nettype none

module nsc_parser #(
   parameter int MAX_CONTENT = 72
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         byte_valid,
   input  wire logic [7:0]   byte_data,
   input  wire logic         out_can_take,
   output logic              consume,
   output logic              res_valid,
   output nsc_pkg::nsc_rsp_type res
);

   localparam int POS_LIMIT = nsc_pkg::HEADER_LEN + MAX_CONTENT;
   localparam int POS_W     = $clog2(POS_LIMIT + 1);

   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_HEAD = 6'b000010,
      MODE_BODY = 6'b000100,
      MODE_SUM1 = 6'b001000,
      MODE_SUM2 = 6'b010000,
      MODE_DONE = 6'b100000
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [7:0]       xor_ff, xor_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      source_ff, source_in;
   logic [23:0]      ident_ff, ident_in;
   logic [3:0]       field_ff, field_in;
   logic [7:0]       sum_ff, sum_in;
   logic             bad_ff, bad_in;
   logic [3:0]       digit_val;
   logic             digit_ok;
   logic [POS_W-1:0] pos_inc;

   // Decode one checksum character; only uppercase hex counts
   always_comb begin
      digit_val = 4'd0;
      digit_ok  = 1'b0;
      if (byte_data >= nsc_pkg::CHAR_ZERO && byte_data <= nsc_pkg::CHAR_NINE) begin
         digit_val = 4'(byte_data - nsc_pkg::CHAR_ZERO);
         digit_ok  = 1'b1;
      end else if (byte_data >= nsc_pkg::CHAR_UPPER_A &&
                   byte_data <= nsc_pkg::CHAR_UPPER_F) begin
         digit_val = 4'(byte_data - nsc_pkg::CHAR_UPPER_A + 8'd10);
         digit_ok  = 1'b1;
      end
   end

   assign pos_inc = pos_ff + POS_W'(1);

   // Next state and optional result for the byte in the input register
   always_comb begin
      mode_in   = mode_ff;
      xor_in    = xor_ff;
      pos_in    = pos_ff;
      source_in = source_ff;
      ident_in  = ident_ff;
      field_in  = field_ff;
      sum_in    = sum_ff;
      bad_in    = bad_ff;
      res_valid = 1'b0;
      res       = '0;

      if (byte_data == nsc_pkg::CHAR_DOLLAR) begin
         // open or reopen a sentence
         mode_in   = MODE_HEAD;
         xor_in    = '0;
         pos_in    = '0;
         source_in = '0;
         ident_in  = '0;
         field_in  = '0;
         sum_in    = '0;
         bad_in    = 1'b0;
      end else if (mode_ff == MODE_IDLE) begin
         // drop bytes outside a sentence
      end else if (byte_data == nsc_pkg::CHAR_LF) begin
         // close the sentence with a verdict
         res_valid         = 1'b1;
         res.kind          = nsc_pkg::KIND_VERDICT;
         res.talker_source = source_ff;
         res.sentence_id   = ident_ff;
         if (mode_ff != MODE_DONE || bad_ff) begin
            res.verdict = nsc_pkg::VERDICT_BAD;
         end else if (sum_ff != xor_ff) begin
            res.verdict = nsc_pkg::VERDICT_MISMATCH;
         end else begin
            res.verdict = nsc_pkg::VERDICT_OK;
         end
         mode_in = MODE_IDLE;
      end else begin
         unique case (mode_ff)
            MODE_HEAD: begin
               if (byte_data == nsc_pkg::CHAR_STAR) begin
                  mode_in = MODE_SUM1;
               end else begin
                  xor_in = xor_ff ^ byte_data;
                  pos_in = pos_inc;
                  if (pos_inc <= POS_W'(2)) begin
                     source_in = {source_ff[7:0], byte_data};
                  end else if (pos_inc <= POS_W'(5)) begin
                     ident_in = {ident_ff[15:0], byte_data};
                  end
                  if (pos_inc >= POS_W'(nsc_pkg::HEADER_LEN)) begin
                     mode_in = MODE_BODY;
                  end
               end
            end
            MODE_BODY: begin
               if (byte_data == nsc_pkg::CHAR_STAR) begin
                  mode_in = MODE_SUM1;
               end else begin
                  xor_in = xor_ff ^ byte_data;
                  if (pos_ff >= POS_W'(POS_LIMIT)) begin
                     // too long: flag and hold position
                     bad_in = 1'b1;
                  end else begin
                     pos_in = pos_inc;
                     if (byte_data == nsc_pkg::CHAR_COMMA) begin
                        if (field_ff < nsc_pkg::MAX_FIELDS) begin
                           field_in = field_ff + 4'd1;
                        end
                     end else if (field_ff < nsc_pkg::MAX_FIELDS) begin
                        res_valid        = 1'b1;
                        res.kind         = nsc_pkg::KIND_CONTENT;
                        res.field_index  = field_ff;
                        res.content_char = byte_data;
                     end
                  end
               end
            end
            MODE_SUM1: begin
               sum_in  = {sum_ff[3:0], digit_val};
               bad_in  = bad_ff | !digit_ok;
               mode_in = MODE_SUM2;
            end
            MODE_SUM2: begin
               sum_in  = {sum_ff[3:0], digit_val};
               bad_in  = bad_ff | !digit_ok;
               mode_in = MODE_DONE;
            end
            MODE_IDLE, MODE_DONE: begin
               // ignore trailing bytes
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // Advance when a byte is present and any result it makes has room
   assign consume = byte_valid && (!res_valid || out_can_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         xor_ff    <= '0;
         pos_ff    <= '0;
         source_ff <= '0;
         ident_ff  <= '0;
         field_ff  <= '0;
         sum_ff    <= '0;
         bad_ff    <= 1'b0;
      end else if (consume) begin
         mode_ff   <= mode_in;
         xor_ff    <= xor_in;
         pos_ff    <= pos_in;
         source_ff <= source_in;
         ident_ff  <= ident_in;
         field_ff  <= field_in;
         sum_ff    <= sum_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

`default_nettype wire

/* sv/nsc_out_reg.sv */
// Result register stage driving the response channel.
`default_nettype none

module nsc_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire nsc_pkg::nsc_rsp_type load_data,
   output logic                      can_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output nsc_pkg::nsc_rsp_type      rsp_data
);

   logic                 valid_ff, valid_in;
   nsc_pkg::nsc_rsp_type data_ff, data_in;

   // Room when empty or the held transaction leaves this cycle
   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

/* sv/nmea_sentence_checker_top.sv */
// Top level of the NMEA sentence checker.
`default_nettype none

// Byte-serial NMEA 0183 sentence checker. One received byte per transaction on
// the request channel; each byte makes at most one response transaction: a
// content character with its field number, or an end-of-sentence verdict
// (ok, checksum mismatch, or incomplete, too long or bad checksum digit)
// carrying the source and message ID. Keep the content of a sentence only
// if its verdict is ok. Throughput is one byte per clock cycle when the
// request side is not stalled; a request passes through the input register,
// then the result register. All per-byte work is a single pass of small
// logic between those two registers; the request side stalls only when a
// result is pending and the response register is still full. MAX_CONTENT
// sets the content length limit and the position counter width.
module nmea_sentence_checker_top #(
   parameter int MAX_CONTENT = 72
) (
   input  wire logic clock,
   input  wire logic reset,
   nsc_req_if.sink   req_chan,
   nsc_rsp_if.source rsp_chan
);

   logic                 byte_valid;
   logic [7:0]           byte_data;
   logic                 consume;
   logic                 res_valid;
   logic                 can_take;
   nsc_pkg::nsc_rsp_type res;
   nsc_pkg::nsc_rsp_type rsp_data;

   // Input register
   nsc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_byte   (req_chan.rx_byte),
      .consume    (consume),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   // Parser
   nsc_parser #(
      .MAX_CONTENT (MAX_CONTENT)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_valid),
      .byte_data    (byte_data),
      .out_can_take (can_take),
      .consume      (consume),
      .res_valid    (res_valid),
      .res          (res)
   );

   // Result register
   nsc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && res_valid),
      .load_data (res),
      .can_take  (can_take),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   // Drive response payload
   assign rsp_chan.kind          = rsp_data.kind;
   assign rsp_chan.field_index   = rsp_data.field_index;
   assign rsp_chan.content_char  = rsp_data.content_char;
   assign rsp_chan.talker_source = rsp_data.talker_source;
   assign rsp_chan.sentence_id   = rsp_data.sentence_id;
   assign rsp_chan.verdict       = rsp_data.verdict;

endmodule

`default_nettype wire
